FILE: hw/rtl/srpt_pkg.sv
// Shared types and codes for the SRPT job scheduler.
// Holds the transaction structs, status and function codes, and ALU opcodes.
// No dependencies.
`default_nettype none

package srpt_pkg;

  typedef enum logic {
    FUNC_ARRIVAL  = 1'b0,
    FUNC_COMPLETE = 1'b1
  } func_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2
  } status_e;

  typedef enum logic {
    ALU_SUB = 1'b0,
    ALU_ADD = 1'b1
  } alu_op_e;

  typedef struct packed {
    func_e       func;
    logic [31:0] now;
    logic [15:0] job_id;
    logic [23:0] job_size;
  } in_item_t;

  typedef struct packed {
    status_e     status;
    logic        running_valid;
    logic [15:0] running_id;
    logic [31:0] finish_time;
    logic        preempted;
    logic [4:0]  job_count;
  } out_item_t;

endpackage

`default_nettype wire

FILE: hw/rtl/srpt_job_scheduler.sv
// Preemptive shortest-remaining-time job scheduler, top level.
// Uses srpt_pkg and srpt_alu; holds the slot table memories.
//
// Input channel (in_valid_i / in_stall_o / in_data_i) carries arrivals and
// completions; output channel (out_valid_o / out_stall_i / out_data_o) returns
// exactly one result per input transaction. A transaction moves at a clock
// edge where valid is high and stall is low.
// One item is processed at a time; in_stall_o is high from acceptance until
// the result is loaded into the output register.
// Steps from accept to result:
//   arrival:    charge of the running job (when a job runs), probe for the
//               lowest free slot (status full if none), store, result
//   completion: id search pass, charge of the running job (when it is not
//               the one completed), minimum search pass over the slot table
// The two table passes read one slot per cycle through the single read port
// of the slot memories.
// Reset empties the table (valid bits cleared at once), no job runs, and the
// block is ready as soon as reset is released.
// A stalled result stays in the output register; the next item is accepted
// meanwhile but its result waits until the register has been taken.
`default_nettype none

module srpt_job_scheduler #(
  parameter int unsigned JOB_SLOTS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  srpt_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output srpt_pkg::out_item_t out_data_o
);

  localparam int unsigned IW = $clog2(JOB_SLOTS);
  localparam int unsigned CW = $clog2(JOB_SLOTS + 1);
  localparam logic [IW:0]   SCAN_END = (IW + 1)'(JOB_SLOTS);
  localparam logic [IW-1:0] LAST     = IW'(JOB_SLOTS - 1);

  typedef enum logic [8:0] {
    S_IDLE    = 9'b000000001,
    S_ELAPSED = 9'b000000010,
    S_CHARGE  = 9'b000000100,
    S_FREE    = 9'b000001000,
    S_STORE   = 9'b000010000,
    S_FIND    = 9'b000100000,
    S_REMOVE  = 9'b001000000,
    S_PICK    = 9'b010000000,
    S_FINISH  = 9'b100000000
  } state_e;

  state_e              state_q, state_d;
  srpt_pkg::in_item_t  item_q, item_d;
  logic [JOB_SLOTS-1:0] valid_q, valid_d;
  logic                busy_q, busy_d;
  logic [IW-1:0]       run_slot_q, run_slot_d;
  logic [31:0]         run_start_q, run_start_d;
  logic [23:0]         run_rem_q, run_rem_d;
  logic [15:0]         run_id_q, run_id_d;
  logic [31:0]         elapsed_q, elapsed_d;
  logic [IW-1:0]       slot_q, slot_d;
  logic [IW:0]         scan_q, scan_d;
  logic                pend_q, pend_d;
  logic [IW-1:0]       chk_q, chk_d;
  logic                found_q, found_d;
  logic [IW-1:0]       best_idx_q, best_idx_d;
  logic [23:0]         best_rem_q, best_rem_d;
  logic [31:0]         best_arr_q, best_arr_d;
  logic [15:0]         best_job_q, best_job_d;
  srpt_pkg::status_e   status_q, status_d;
  logic                preempt_q, preempt_d;
  logic [CW-1:0]       count_q, count_d;
  logic                out_valid_q, out_valid_d;
  srpt_pkg::out_item_t out_q, out_d;

  // slot table
  logic [15:0] job_mem [JOB_SLOTS];
  logic [23:0] rem_mem [JOB_SLOTS];
  logic [31:0] arr_mem [JOB_SLOTS];
  logic [15:0] rd_job_q;
  logic [23:0] rd_rem_q;
  logic [31:0] rd_arr_q;
  logic        mem_we_all, mem_we_rem;
  logic [IW-1:0] wr_addr, rd_addr;
  logic [23:0] wr_rem;

  srpt_pkg::alu_op_e alu_op;
  logic [31:0] alu_a, alu_b, alu_res;
  logic        alu_carry;

  logic [23:0] charged_rem;
  logic [CW+4:0] count_ext;

  srpt_alu u_alu (
    .op_i   (alu_op),
    .a_i    (alu_a),
    .b_i    (alu_b),
    .res_o  (alu_res),
    .carry_o(alu_carry)
  );

  assign charged_rem = alu_carry ? 24'd0 : alu_res[23:0];
  assign count_ext   = {5'd0, count_q};

  always_comb begin
    state_d     = state_q;
    item_d      = item_q;
    valid_d     = valid_q;
    busy_d      = busy_q;
    run_slot_d  = run_slot_q;
    run_start_d = run_start_q;
    run_rem_d   = run_rem_q;
    run_id_d    = run_id_q;
    elapsed_d   = elapsed_q;
    slot_d      = slot_q;
    scan_d      = scan_q;
    pend_d      = pend_q;
    chk_d       = chk_q;
    found_d     = found_q;
    best_idx_d  = best_idx_q;
    best_rem_d  = best_rem_q;
    best_arr_d  = best_arr_q;
    best_job_d  = best_job_q;
    status_d    = status_q;
    preempt_d   = preempt_q;
    count_d     = count_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    mem_we_all  = 1'b0;
    mem_we_rem  = 1'b0;
    wr_addr     = slot_q;
    wr_rem      = item_q.job_size;
    rd_addr     = scan_q[IW-1:0];
    alu_op      = srpt_pkg::ALU_SUB;
    alu_a       = item_q.now;
    alu_b       = run_start_q;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          item_d    = in_data_i;
          status_d  = srpt_pkg::ST_OK;
          preempt_d = 1'b0;
          scan_d    = '0;
          pend_d    = 1'b0;
          found_d   = 1'b0;
          if (in_data_i.func == srpt_pkg::FUNC_ARRIVAL) begin
            state_d = busy_q ? S_ELAPSED : S_FREE;
          end else begin
            state_d = S_FIND;
          end
        end
      end

      // time going backwards counts as no elapsed time
      S_ELAPSED: begin
        elapsed_d = alu_carry ? 32'd0 : alu_res;
        state_d   = S_CHARGE;
      end

      S_CHARGE: begin
        alu_a       = {8'd0, run_rem_q};
        alu_b       = elapsed_q;
        run_rem_d   = charged_rem;
        run_start_d = item_q.now;
        mem_we_rem  = 1'b1;
        wr_addr     = run_slot_q;
        wr_rem      = charged_rem;
        state_d     = (item_q.func == srpt_pkg::FUNC_ARRIVAL) ? S_FREE : S_REMOVE;
      end

      S_FREE: begin
        if (!valid_q[scan_q[IW-1:0]]) begin
          slot_d  = scan_q[IW-1:0];
          state_d = S_STORE;
        end else if (scan_q[IW-1:0] == LAST) begin
          status_d = srpt_pkg::ST_FULL;
          state_d  = S_FINISH;
        end else begin
          scan_d = scan_q + (IW + 1)'(1);
        end
      end

      // borrow of size - remaining means the new job is strictly shorter
      S_STORE: begin
        alu_a           = {8'd0, item_q.job_size};
        alu_b           = {8'd0, run_rem_q};
        mem_we_all      = 1'b1;
        valid_d[slot_q] = 1'b1;
        count_d         = count_q + CW'(1);
        if (!busy_q || alu_carry) begin
          busy_d      = 1'b1;
          run_slot_d  = slot_q;
          run_start_d = item_q.now;
          run_rem_d   = item_q.job_size;
          run_id_d    = item_q.job_id;
          preempt_d   = busy_q;
        end
        state_d = S_FINISH;
      end

      S_FIND: begin
        if (scan_q != SCAN_END) begin
          scan_d = scan_q + (IW + 1)'(1);
          pend_d = 1'b1;
          chk_d  = scan_q[IW-1:0];
        end else begin
          pend_d = 1'b0;
        end
        if (pend_q) begin
          if (valid_q[chk_q] && rd_job_q == item_q.job_id) begin
            slot_d  = chk_q;
            state_d = (busy_q && run_slot_q != chk_q) ? S_ELAPSED : S_REMOVE;
          end else if (chk_q == LAST) begin
            status_d = srpt_pkg::ST_NOT_FOUND;
            state_d  = S_FINISH;
          end
        end
      end

      S_REMOVE: begin
        valid_d[slot_q] = 1'b0;
        count_d         = count_q - CW'(1);
        scan_d          = '0;
        pend_d          = 1'b0;
        found_d         = 1'b0;
        state_d         = S_PICK;
      end

      // least remaining time, ties to earliest arrival, then lowest slot
      S_PICK: begin
        if (scan_q != SCAN_END) begin
          scan_d = scan_q + (IW + 1)'(1);
          pend_d = 1'b1;
          chk_d  = scan_q[IW-1:0];
        end else begin
          pend_d = 1'b0;
        end
        if (pend_q) begin
          if (valid_q[chk_q] &&
              (!found_q || rd_rem_q < best_rem_q ||
               (rd_rem_q == best_rem_q && rd_arr_q < best_arr_q))) begin
            found_d    = 1'b1;
            best_idx_d = chk_q;
            best_rem_d = rd_rem_q;
            best_arr_d = rd_arr_q;
            best_job_d = rd_job_q;
          end
          if (chk_q == LAST) begin
            busy_d     = found_d;
            run_slot_d = found_d ? best_idx_d : '0;
            if (found_d) begin
              run_start_d = item_q.now;
              run_rem_d   = best_rem_d;
              run_id_d    = best_job_d;
            end
            state_d = S_FINISH;
          end
        end
      end

      S_FINISH: begin
        alu_op = srpt_pkg::ALU_ADD;
        alu_a  = run_start_q;
        alu_b  = {8'd0, run_rem_q};
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d         = 1'b1;
          out_d.status        = status_q;
          out_d.running_valid = busy_q;
          out_d.running_id    = busy_q ? run_id_q : 16'd0;
          out_d.finish_time   = busy_q ? (alu_carry ? 32'hFFFF_FFFF : alu_res) : 32'd0;
          out_d.preempted     = preempt_q;
          out_d.job_count     = count_ext[4:0];
          state_d             = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      item_q      <= '0;
      valid_q     <= '0;
      busy_q      <= 1'b0;
      run_slot_q  <= '0;
      run_start_q <= '0;
      run_rem_q   <= '0;
      run_id_q    <= '0;
      elapsed_q   <= '0;
      slot_q      <= '0;
      scan_q      <= '0;
      pend_q      <= 1'b0;
      chk_q       <= '0;
      found_q     <= 1'b0;
      best_idx_q  <= '0;
      best_rem_q  <= '0;
      best_arr_q  <= '0;
      best_job_q  <= '0;
      status_q    <= srpt_pkg::ST_OK;
      preempt_q   <= 1'b0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      state_q     <= state_d;
      item_q      <= item_d;
      valid_q     <= valid_d;
      busy_q      <= busy_d;
      run_slot_q  <= run_slot_d;
      run_start_q <= run_start_d;
      run_rem_q   <= run_rem_d;
      run_id_q    <= run_id_d;
      elapsed_q   <= elapsed_d;
      slot_q      <= slot_d;
      scan_q      <= scan_d;
      pend_q      <= pend_d;
      chk_q       <= chk_d;
      found_q     <= found_d;
      best_idx_q  <= best_idx_d;
      best_rem_q  <= best_rem_d;
      best_arr_q  <= best_arr_d;
      best_job_q  <= best_job_d;
      status_q    <= status_d;
      preempt_q   <= preempt_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
      out_q       <= out_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we_all) begin
      job_mem[wr_addr] <= item_q.job_id;
      arr_mem[wr_addr] <= item_q.now;
    end
    if (mem_we_all || mem_we_rem) begin
      rem_mem[wr_addr] <= wr_rem;
    end
    rd_job_q <= job_mem[rd_addr];
    rd_rem_q <= rem_mem[rd_addr];
    rd_arr_q <= arr_mem[rd_addr];
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

FILE: hw/rtl/srpt_alu.sv
// Shared 32-bit add/subtract unit of the SRPT scheduler.
// Carry out is the add overflow or the subtract borrow. Depends on srpt_pkg.
`default_nettype none

module srpt_alu (
  input  srpt_pkg::alu_op_e op_i,
  input  logic [31:0]       a_i,
  input  logic [31:0]       b_i,
  output logic [31:0]       res_o,
  output logic              carry_o
);

  logic [32:0] sum;

  always_comb begin
    if (op_i == srpt_pkg::ALU_ADD) begin
      sum = {1'b0, a_i} + {1'b0, b_i};
    end else begin
      sum = {1'b0, a_i} - {1'b0, b_i};
    end
  end

  assign res_o   = sum[31:0];
  assign carry_o = sum[32];

endmodule

`default_nettype wire

FILE: bench/srpt_sched_tracker_pkg.sv
`timescale 1ns / 1ps
// Job table tracker for the SRPT scheduler bench: predicts each result and checks the DUT.
// Depends on srpt_pkg for the transaction structs and codes.
package srpt_sched_tracker_pkg;
  import srpt_pkg::*;

  localparam int unsigned SLOTS = 16;

  class schedule_tracker;
    bit          slot_used[SLOTS];
    bit [15:0]   slot_id[SLOTS];
    bit [23:0]   slot_left[SLOTS];
    bit [31:0]   slot_arrived[SLOTS];
    bit          busy;
    int unsigned run_slot;
    bit [31:0]   run_since;

    out_item_t   due_results[$];

    int unsigned errors;
    int unsigned n_checked;
    int unsigned n_arrivals;
    int unsigned n_completions;
    int unsigned n_full;
    int unsigned n_missing;
    int unsigned n_preempt;
    int unsigned peak_jobs;

    function int unsigned pending();
      return due_results.size();
    endfunction

    function int unsigned live_count();
      int unsigned cnt;
      cnt = 0;
      foreach (slot_used[i]) if (slot_used[i]) cnt++;
      return cnt;
    endfunction

    // id of a random job held in the table, or a random id when empty
    function bit [15:0] pick_live_id();
      int unsigned idx[$];
      foreach (slot_used[i]) if (slot_used[i]) idx.push_back(i);
      if (idx.size() == 0) return 16'($urandom);
      return slot_id[idx[$urandom_range(0, idx.size() - 1)]];
    endfunction

    // bill elapsed ticks to the running job; time going backwards bills nothing
    function void charge(bit [31:0] now);
      bit [31:0] spent;
      if (!busy) return;
      spent = (now >= run_since) ? now - run_since : 32'd0;
      if ({8'd0, slot_left[run_slot]} > spent) slot_left[run_slot] -= spent[23:0];
      else slot_left[run_slot] = '0;
      run_since = now;
    endfunction

    // least remaining time wins, then earliest arrival, then lowest slot
    function void start_shortest(bit [31:0] now);
      bit          found;
      int unsigned best;
      found = 1'b0;
      best  = 0;
      for (int unsigned i = 0; i < SLOTS; i++) begin
        if (slot_used[i] && (!found || slot_left[i] < slot_left[best] ||
            (slot_left[i] == slot_left[best] && slot_arrived[i] < slot_arrived[best]))) begin
          best  = i;
          found = 1'b1;
        end
      end
      busy     = found;
      run_slot = found ? best : 0;
      if (found) run_since = now;
    endfunction

    function void apply_item(in_item_t it);
      out_item_t   res;
      int unsigned slot;
      bit          hit;
      bit [32:0]   fin;
      res  = '0;
      slot = 0;
      hit  = 1'b0;
      if (it.func == FUNC_ARRIVAL) begin
        n_arrivals++;
        charge(it.now);
        for (int unsigned i = 0; i < SLOTS; i++) begin
          if (!slot_used[i] && !hit) begin
            slot = i;
            hit  = 1'b1;
          end
        end
        if (!hit) begin
          res.status = ST_FULL;
          n_full++;
        end else begin
          slot_used[slot]    = 1'b1;
          slot_id[slot]      = it.job_id;
          slot_left[slot]    = it.job_size;
          slot_arrived[slot] = it.now;
          if (!busy) begin
            busy      = 1'b1;
            run_slot  = slot;
            run_since = it.now;
          end else if (it.job_size < slot_left[run_slot]) begin
            run_slot      = slot;
            run_since     = it.now;
            res.preempted = 1'b1;
            n_preempt++;
          end
        end
      end else begin
        n_completions++;
        for (int unsigned i = 0; i < SLOTS; i++) begin
          if (slot_used[i] && slot_id[i] == it.job_id && !hit) begin
            slot = i;
            hit  = 1'b1;
          end
        end
        if (!hit) begin
          res.status = ST_NOT_FOUND;
          n_missing++;
        end else begin
          if (busy && run_slot != slot) charge(it.now);
          slot_used[slot] = 1'b0;
          start_shortest(it.now);
        end
      end
      res.running_valid = busy;
      if (busy) begin
        res.running_id = slot_id[run_slot];
        fin = {1'b0, run_since} + {9'd0, slot_left[run_slot]};
        res.finish_time = fin[32] ? 32'hFFFF_FFFF : fin[31:0];
      end
      res.job_count = 5'(live_count());
      if (res.job_count > peak_jobs) peak_jobs = res.job_count;
      due_results.push_back(res);
    endfunction

    function void compare(string what, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        errors++;
        $display("%0t: %s mismatch, expected %0h actual %0h", $time, what, want, got);
      end
    endfunction

    function void take_result(out_item_t got);
      out_item_t want;
      if (due_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none actual %0h", $time, got);
        return;
      end
      want = due_results.pop_front();
      n_checked++;
      compare("status", want.status, got.status);
      compare("running_valid", want.running_valid, got.running_valid);
      compare("running_id", want.running_id, got.running_id);
      compare("finish_time", want.finish_time, got.finish_time);
      compare("preempted", want.preempted, got.preempted);
      compare("job_count", want.job_count, got.job_count);
    endfunction
  endclass

endpackage

FILE: bench/srpt_job_scheduler_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for srpt_job_scheduler: directed job sequences, then random traffic.
// Depends on srpt_pkg and srpt_sched_tracker_pkg.
module srpt_job_scheduler_tb;
  import srpt_pkg::*;
  import srpt_sched_tracker_pkg::*;

  localparam int unsigned LIMIT         = 1_000_000;
  localparam int unsigned HOLD_CYCLES   = 400;
  localparam int unsigned PER_PHASE     = 94;
  localparam int unsigned SETTLE_CYCLES = 2 * SLOTS + 16;

  logic      clk;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  in_item_t  in_data   = '0;
  logic      in_stall;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;

  schedule_tracker tracker;
  int unsigned     cycles    = 0;
  int unsigned     idle_pct  = 0;
  int unsigned     stall_pct = 0;
  int unsigned     hold_ask  = 0;
  int unsigned     arrive_pct = 55;
  logic [31:0]     tick      = '0;

  srpt_job_scheduler #(.JOB_SLOTS(SLOTS)) dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, tracker.pending());
      $display("srpt_job_scheduler_tb failed");
      $finish;
    end
  end

  // result side: check each transaction, stall at random or for a long hold
  int unsigned hold_seen = 0;
  int unsigned hold_left = 0;
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) tracker.take_result(out_data);
    if (hold_ask != hold_seen) begin
      hold_seen = hold_ask;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  function automatic in_item_t mk(func_e f, logic [31:0] t, logic [15:0] id, logic [23:0] sz);
    in_item_t it;
    it.func     = f;
    it.now      = t;
    it.job_id   = id;
    it.job_size = sz;
    return it;
  endfunction

  function automatic in_item_t random_item();
    in_item_t    it;
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 3) tick = tick - $urandom_range(1, 500);
    else if (r < 5) tick = 32'hFFFF_FFFF - $urandom_range(0, 4000);
    else if (r < 8) tick = $urandom;
    else tick = tick + $urandom_range(0, 40);
    // switch between filling, steady and draining the table now and then
    if ($urandom_range(0, 29) == 0) begin
      r = $urandom_range(0, 2);
      arrive_pct = (r == 0) ? 25 : (r == 1) ? 55 : 85;
    end
    it.now = tick;
    if ($urandom_range(0, 99) < arrive_pct) begin
      it.func   = FUNC_ARRIVAL;
      it.job_id = ($urandom_range(0, 99) < 70) ? 16'($urandom_range(0, 23)) : 16'($urandom);
      r = $urandom_range(0, 99);
      if (r < 5) it.job_size = '0;
      else if (r < 55) it.job_size = 24'($urandom_range(1, 60));
      else if (r < 70) it.job_size = 24'($urandom_range(1, 6));
      else if (r < 85) it.job_size = 24'($urandom_range(1, 24'hFFFFFF));
      else if (r < 95) it.job_size = 24'($urandom);
      else it.job_size = 24'hFFFFFF;
    end else begin
      it.func = FUNC_COMPLETE;
      r = $urandom_range(0, 99);
      if (r < 80) it.job_id = tracker.pick_live_id();
      else if (r < 90) it.job_id = 16'($urandom_range(0, 31));
      else it.job_id = 16'($urandom);
      it.job_size = 24'($urandom);
    end
    return it;
  endfunction

  task automatic send_item(in_item_t it);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall);
    tracker.apply_item(it);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
  endtask

  task automatic directed();
    int unsigned n;
    n = 0;
    send_item(mk(FUNC_COMPLETE, 32'd10, 16'd5, 24'd0));           // empty table, idle result
    send_item(mk(FUNC_ARRIVAL, 32'd100, 16'hFFFF, 24'hFFFFFF));
    send_item(mk(FUNC_ARRIVAL, 32'd200, 16'd1, 24'd50));           // preempts
    send_item(mk(FUNC_ARRIVAL, 32'd210, 16'd2, 24'd50));
    send_item(mk(FUNC_ARRIVAL, 32'd210, 16'd3, 24'd40));           // equal, no preempt
    send_item(mk(FUNC_ARRIVAL, 32'd215, 16'd4, 24'd0));            // zero size
    send_item(mk(FUNC_ARRIVAL, 32'd215, 16'd2, 24'd7));            // duplicate id
    send_item(mk(FUNC_COMPLETE, 32'd220, 16'd4, 24'hFFFFFF));
    send_item(mk(FUNC_COMPLETE, 32'd230, 16'd2, 24'd0));           // lowest slot holding id
    send_item(mk(FUNC_ARRIVAL, 32'd100, 16'd9, 24'd3));            // time goes backwards
    send_item(mk(FUNC_COMPLETE, 32'd300, 16'd7, 24'd0));           // unknown id
    send_item(mk(FUNC_ARRIVAL, 32'hFFFF_FF00, 16'd10, 24'd1000));  // over-charge clamps
    send_item(mk(FUNC_COMPLETE, 32'hFFFF_FF10, tracker.slot_id[tracker.run_slot], 24'd0));
    while (tracker.live_count() < SLOTS) begin
      send_item(mk(FUNC_ARRIVAL, 32'hFFFF_FF20 + n, 16'(16'h0100 + n),
                   24'(24'h000100 + n)));
      n++;
    end
    send_item(mk(FUNC_ARRIVAL, 32'hFFFF_FFF0, 16'h0A5A, 24'd1));   // table full
    send_item(mk(FUNC_ARRIVAL, 32'hFFFF_FFFF, 16'h5A5A, 24'd2));
    drain();
  endtask

  initial begin
    tracker = new;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    directed();
    tick = 32'd1000;
    for (int unsigned ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin
          idle_pct = 0;
          stall_pct <= 0;
        end
        1: begin
          idle_pct = 53;
          stall_pct <= 0;
        end
        2: begin
          idle_pct = 0;
          stall_pct <= 53;
        end
        default: begin
          idle_pct = 9;
          stall_pct <= 9;
        end
      endcase
      // long hold on the result side while items keep coming
      if (ph == 4) hold_ask <= hold_ask + 1;
      repeat (PER_PHASE) send_item(random_item());
      drain();
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("covered %0d arrivals, %0d completions: %0d full, %0d unknown ids, %0d preemptions",
             tracker.n_arrivals, tracker.n_completions, tracker.n_full, tracker.n_missing,
             tracker.n_preempt);
    $display("%0d results checked, peak occupancy %0d of %0d slots",
             tracker.n_checked, tracker.peak_jobs, SLOTS);
    if (tracker.errors == 0) begin
      $display("srpt_job_scheduler_tb passed");
    end else begin
      $display("srpt_job_scheduler_tb failed");
    end
    $finish;
  end

endmodule

FILE: files.f
hw/rtl/srpt_pkg.sv
hw/rtl/srpt_alu.sv
hw/rtl/srpt_job_scheduler.sv
bench/srpt_sched_tracker_pkg.sv
bench/srpt_job_scheduler_tb.sv
